>>> hw/rtl/wfd_pkg.sv
// -----------------------------------------------------------------------------
// WebSocket frame deframer package
// Beat types for the byte and result channels, and status codes.
// -----------------------------------------------------------------------------
package wfd_pkg;

   // status codes reported with the last byte of a buffer
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_UNMASKED  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
   localparam logic [1:0] STATUS_LENGTH    = 2'd3;

   // one raw byte of the received buffer
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_buffer;
   } wfd_req_type;

   // one result beat: payload byte and/or frame status
   typedef struct packed {
      logic        has_data;
      logic [7:0]  out_byte;
      logic        frame_done;
      logic [1:0]  status;
      logic        fin_flag;
      logic [3:0]  frame_opcode;
      logic [62:0] payload_length;
   } wfd_rsp_type;

endpackage

>>> hw/rtl/wfd_input_reg.sv
// -----------------------------------------------------------------------------
// WebSocket frame deframer input register
// Holds one accepted byte beat until the parser consumes it.
// -----------------------------------------------------------------------------
module wfd_input_reg
   import wfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  wfd_req_type req_payload,
   input  logic        pop,
   output logic        item_valid,
   output wfd_req_type item
);

   logic        valid_ff;
   logic        valid_in;
   logic        load;
   wfd_req_type data_ff;

   // stall only while a held beat is not moving on
   assign req_stall = valid_ff & ~pop;
   assign load      = req_valid & ~req_stall;
   assign valid_in  = load | (valid_ff & ~pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture a new beat
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

>>> hw/rtl/wfd_parser.sv
// -----------------------------------------------------------------------------
// WebSocket frame deframer parser
// Header state machine, mask key, payload unmasking and end-of-buffer status.
// -----------------------------------------------------------------------------
module wfd_parser
   import wfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  wfd_req_type item,
   input  logic        commit,
   output logic        emit,
   output wfd_rsp_type result
);

   localparam logic [2:0] PH_FIRST   = 3'd0;
   localparam logic [2:0] PH_SECOND  = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;
   localparam logic [2:0] PH_DISCARD = 3'd5;

   localparam logic [6:0] LEN_CODE_SHORT_MAX = 7'd125;
   localparam logic [6:0] LEN_CODE_EXT16     = 7'd126;
   localparam logic [3:0] EXT16_BYTES        = 4'd2;
   localparam logic [3:0] EXT64_BYTES        = 4'd8;

   logic [2:0]  phase_ff,    phase_in;
   logic        fin_ff,      fin_in;
   logic [3:0]  opcode_ff,   opcode_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [63:0] decl_ff,     decl_in;
   logic [31:0] key_ff,      key_in;
   logic [1:0]  key_idx_ff,  key_idx_in;
   logic [63:0] seen_ff,     seen_in;
   logic [1:0]  err_ff,      err_in;

   logic [7:0]  b;
   logic [6:0]  len_code;
   logic [3:0]  ext_dec;
   logic [7:0]  key_byte;
   logic        has;
   logic [7:0]  ob;
   logic [1:0]  st;

   assign b        = item.in_byte;
   assign len_code = b[6:0];
   assign ext_dec  = (ext_left_ff != 4'd0) ? ext_left_ff - 4'd1 : ext_left_ff;

   // pick the key byte for this payload position, first received key byte first
   always_comb begin
      unique case (key_idx_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   // advance the header state for one byte
   always_comb begin
      phase_in    = phase_ff;
      fin_in      = fin_ff;
      opcode_in   = opcode_ff;
      ext_left_in = ext_left_ff;
      decl_in     = decl_ff;
      key_in      = key_ff;
      key_idx_in  = key_idx_ff;
      seen_in     = seen_ff;
      err_in      = err_ff;
      has         = 1'b0;
      ob          = 8'd0;
      unique case (phase_ff)
         PH_FIRST: begin
            fin_in    = b[7];
            opcode_in = b[3:0];
            phase_in  = PH_SECOND;
         end
         PH_SECOND: begin
            if (!b[7] && err_ff == STATUS_OK) begin
               err_in = STATUS_UNMASKED;
            end
            if (len_code <= LEN_CODE_SHORT_MAX) begin
               decl_in  = {57'd0, len_code};
               phase_in = (err_in == STATUS_UNMASKED) ? PH_DISCARD : PH_KEY;
            end else begin
               decl_in     = 64'd0;
               ext_left_in = (len_code == LEN_CODE_EXT16) ? EXT16_BYTES : EXT64_BYTES;
               phase_in    = PH_EXTLEN;
            end
         end
         PH_EXTLEN: begin
            decl_in     = {decl_ff[55:0], b};
            ext_left_in = ext_dec;
            if (ext_dec == 4'd0) begin
               phase_in = (err_ff == STATUS_UNMASKED) ? PH_DISCARD : PH_KEY;
            end
         end
         PH_KEY: begin
            key_in     = {key_ff[23:0], b};
            key_idx_in = key_idx_ff + 2'd1;
            if (key_idx_in == 2'd0) begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            ob         = b ^ key_byte;
            has        = 1'b1;
            key_idx_in = key_idx_ff + 2'd1;
            if (seen_ff != {64{1'b1}}) begin
               seen_in = seen_ff + 64'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // first latched error wins, then truncation, then length check
   always_comb begin
      st = err_in;
      if (err_in == STATUS_OK) begin
         if (phase_in < PH_PAYLOAD) begin
            st = STATUS_TRUNCATED;
         end else if (phase_in == PH_PAYLOAD && seen_in != decl_in) begin
            st = STATUS_LENGTH;
         end
      end
   end

   // build the result beat
   always_comb begin
      result                = '0;
      result.has_data       = has;
      result.out_byte       = ob;
      if (item.end_of_buffer) begin
         result.frame_done     = 1'b1;
         result.status         = st;
         result.fin_flag       = fin_in;
         result.frame_opcode   = opcode_in;
         result.payload_length = decl_in[62:0];
      end
   end

   assign emit = has | item.end_of_buffer;

   // commit state; drop everything back to the first header byte at buffer end
   always_ff @(posedge clock) begin
      if (reset || (commit && item.end_of_buffer)) begin
         phase_ff    <= PH_FIRST;
         fin_ff      <= 1'b0;
         opcode_ff   <= 4'd0;
         ext_left_ff <= 4'd0;
         decl_ff     <= 64'd0;
         key_ff      <= 32'd0;
         key_idx_ff  <= 2'd0;
         seen_ff     <= 64'd0;
         err_ff      <= STATUS_OK;
      end else if (commit) begin
         phase_ff    <= phase_in;
         fin_ff      <= fin_in;
         opcode_ff   <= opcode_in;
         ext_left_ff <= ext_left_in;
         decl_ff     <= decl_in;
         key_ff      <= key_in;
         key_idx_ff  <= key_idx_in;
         seen_ff     <= seen_in;
         err_ff      <= err_in;
      end
   end

endmodule

>>> hw/rtl/wfd_output_reg.sv
// -----------------------------------------------------------------------------
// WebSocket frame deframer output register
// Holds one result beat until the consumer takes it.
// -----------------------------------------------------------------------------
module wfd_output_reg
   import wfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  wfd_rsp_type result,
   output logic        free,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output wfd_rsp_type rsp_payload
);

   logic        valid_ff;
   logic        valid_in;
   wfd_rsp_type data_ff;

   // room when empty or when the held beat leaves this cycle
   assign free     = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture a new result beat
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

endmodule

>>> hw/rtl/websocket_frame_deframer_unit.sv
// -----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses one received buffer byte by byte and emits unmasked payload and status.
// -----------------------------------------------------------------------------
// The block takes one byte beat per cycle. Each accepted byte is held in the input
// register while one pass of header/unmask logic feeds the output register, which
// presents the result. Header bytes and bytes of an unmasked frame give no result
// beat; payload bytes give one beat with the unmasked byte, and the byte flagged
// as end of buffer gives one beat that also carries fin, opcode, declared length
// and status. The parser then starts over for the next buffer. Sustained rate is
// one byte per cycle, held back only while the output register waits on rsp_stall.
module websocket_frame_deframer_unit
   import wfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  wfd_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output wfd_rsp_type rsp_payload
);

   logic        item_valid;
   wfd_req_type item;
   logic        emit;
   wfd_rsp_type result;
   logic        out_free;
   logic        advance;

   // move the held byte when its result has room, or when it has no result
   assign advance = item_valid & (out_free | ~emit);

   wfd_input_reg u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .pop         (advance),
      .item_valid  (item_valid),
      .item        (item)
   );

   wfd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .commit (advance),
      .emit   (emit),
      .result (result)
   );

   wfd_output_reg u_output (
      .clock       (clock),
      .reset       (reset),
      .load        (advance & emit),
      .result      (result),
      .free        (out_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
